// ===== sv/phtp_pkg.sv =====
package phtp_pkg;

  localparam int COORD_W    = 16;
  localparam int TILE_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NDIM_W     = 12;
  localparam int ZDIM_W     = 13;

  // register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_NORMAL_WIDTH  = 3'd2,
    CFG_NORMAL_HEIGHT = 3'd3,
    CFG_ZOOMED_WIDTH  = 3'd4,
    CFG_ZOOMED_HEIGHT = 3'd5,
    CFG_ZOOM_ON       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [NDIM_W-1:0]         normal_width;
    logic [NDIM_W-1:0]         normal_height;
    logic [ZDIM_W-1:0]         zoomed_width;
    logic [ZDIM_W-1:0]         zoomed_height;
    logic                      zoom_on;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COL,
    ST_ODD,
    ST_EVEN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic col_next;
    logic odd_init;
    logic even_init;
    logic row_next;
    logic capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic x_in_odd;
    logic x_in_even;
    logic row_ok;
    logic hit;
    logic lower_miss;
  } dp_stat_t;

endpackage

// ===== sv/phtp_if.sv =====
interface phtp_click_if;
  logic                               valid;
  logic                               ready;
  logic signed [phtp_pkg::COORD_W-1:0] click_x;
  logic signed [phtp_pkg::COORD_W-1:0] click_y;

  modport source (output valid, output click_x, output click_y, input ready);
  modport sink   (input valid, input click_x, input click_y, output ready);
endinterface

interface phtp_tile_if;
  logic                          valid;
  logic                          ready;
  logic [phtp_pkg::TILE_W-1:0]   tile_col;
  logic [phtp_pkg::TILE_W-1:0]   tile_row;

  modport source (output valid, output tile_col, output tile_row, input ready);
  modport sink   (input valid, input tile_col, input tile_row, output ready);
endinterface

interface phtp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [phtp_pkg::CFG_IDX_W-1:0]    index;
  logic [phtp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/phtp_cfg_regs.sv =====
module phtp_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  phtp_cfg_if.sink        cfg_i,
  output phtp_pkg::cfg_t  cfg_o
);

  phtp_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (phtp_pkg::cfg_idx_e'(cfg_i.index))
        phtp_pkg::CFG_CENTER_X:      cfg_q.center_x      <= cfg_i.data[15:0];
        phtp_pkg::CFG_CENTER_Y:      cfg_q.center_y      <= cfg_i.data[15:0];
        phtp_pkg::CFG_NORMAL_WIDTH:  cfg_q.normal_width  <= cfg_i.data[11:0];
        phtp_pkg::CFG_NORMAL_HEIGHT: cfg_q.normal_height <= cfg_i.data[11:0];
        phtp_pkg::CFG_ZOOMED_WIDTH:  cfg_q.zoomed_width  <= cfg_i.data[12:0];
        phtp_pkg::CFG_ZOOMED_HEIGHT: cfg_q.zoomed_height <= cfg_i.data[12:0];
        phtp_pkg::CFG_ZOOM_ON:       cfg_q.zoom_on       <= cfg_i.data[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

// ===== sv/phtp_ctrl.sv =====
module phtp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  phtp_pkg::dp_stat_t  stat_i,
  output phtp_pkg::dp_cmd_t   cmd_o
);

  phtp_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             row_exit;

  assign out_free = !out_valid_q || out_ready_i;
  assign row_exit = !stat_i.row_ok || stat_i.lower_miss;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      phtp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = phtp_pkg::ST_LOAD;
      end
      phtp_pkg::ST_LOAD: begin
        state_d = phtp_pkg::ST_COL;
      end
      phtp_pkg::ST_COL: begin
        if (!stat_i.col_ok)        state_d = phtp_pkg::ST_DONE;
        else if (stat_i.x_in_odd)  state_d = phtp_pkg::ST_ODD;
        else if (stat_i.x_in_even) state_d = phtp_pkg::ST_EVEN;
      end
      phtp_pkg::ST_ODD: begin
        if (stat_i.row_ok && stat_i.hit) state_d = phtp_pkg::ST_DONE;
        else if (row_exit) begin
          state_d = stat_i.x_in_even ? phtp_pkg::ST_EVEN : phtp_pkg::ST_COL;
        end
      end
      phtp_pkg::ST_EVEN: begin
        if (stat_i.row_ok && stat_i.hit) state_d = phtp_pkg::ST_DONE;
        else if (row_exit)               state_d = phtp_pkg::ST_COL;
      end
      phtp_pkg::ST_DONE: begin
        if (out_free) state_d = phtp_pkg::ST_IDLE;
      end
      default: state_d = phtp_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      phtp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      phtp_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      phtp_pkg::ST_COL: begin
        if (stat_i.col_ok) begin
          if (stat_i.x_in_odd)       cmd_o.odd_init  = 1'b1;
          else if (stat_i.x_in_even) cmd_o.even_init = 1'b1;
          else                       cmd_o.col_next  = 1'b1;
        end
      end
      phtp_pkg::ST_ODD: begin
        if (stat_i.row_ok && stat_i.hit) cmd_o.capture = 1'b1;
        else if (row_exit) begin
          if (stat_i.x_in_even) cmd_o.even_init = 1'b1;
          else                  cmd_o.col_next  = 1'b1;
        end else begin
          cmd_o.row_next = 1'b1;
        end
      end
      phtp_pkg::ST_EVEN: begin
        if (stat_i.row_ok && stat_i.hit) cmd_o.capture  = 1'b1;
        else if (row_exit)               cmd_o.col_next = 1'b1;
        else                             cmd_o.row_next = 1'b1;
      end
      phtp_pkg::ST_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= phtp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == phtp_pkg::ST_ODD || state_q == phtp_pkg::ST_EVEN)
      && stat_i.row_ok && stat_i.hit |=> state_q == phtp_pkg::ST_DONE)
    else $error("hit did not end the scan");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == phtp_pkg::ST_DONE && out_valid_q && !out_ready_i
      |=> state_q == phtp_pkg::ST_DONE && out_valid_q)
    else $error("result overwritten while output busy");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == phtp_pkg::ST_DONE)
    else $error("output valid raised outside done");

  a_load_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == phtp_pkg::ST_LOAD |-> $past(in_valid_i) && $past(state_q) == phtp_pkg::ST_IDLE)
    else $error("load without an accepted word");

endmodule

// ===== sv/phtp_dp.sv =====
module phtp_dp #(
  parameter int NORMAL_TILE_SIZE = 100,
  parameter int ZOOM_TILE_SIZE   = 200,
  parameter int MAX_TILES        = 63
) (
  input  logic                                clk_i,
  input  phtp_pkg::cfg_t                      cfg_i,
  input  logic signed [phtp_pkg::COORD_W-1:0] click_x_i,
  input  logic signed [phtp_pkg::COORD_W-1:0] click_y_i,
  input  phtp_pkg::dp_cmd_t                   cmd_i,
  output phtp_pkg::dp_stat_t                  stat_o,
  output logic [phtp_pkg::TILE_W-1:0]         tile_col_o,
  output logic [phtp_pkg::TILE_W-1:0]         tile_row_o
);

  localparam int TSMAX = (ZOOM_TILE_SIZE > NORMAL_TILE_SIZE) ? ZOOM_TILE_SIZE
                                                             : NORMAL_TILE_SIZE;
  localparam int AW = $clog2(TSMAX * (MAX_TILES + 4) * 4 + 2**17) + 2;
  localparam int CW = $clog2(MAX_TILES + 2);
  localparam int RW = $clog2(MAX_TILES + 3);
  localparam int TW = phtp_pkg::TILE_W;

  localparam int N_TS   = NORMAL_TILE_SIZE;
  localparam int N_HALF = NORMAL_TILE_SIZE / 2;
  localparam int N_Q1   = NORMAL_TILE_SIZE / 4;
  localparam int N_Q3   = (3 * NORMAL_TILE_SIZE) / 4;
  localparam int N_Q5   = (5 * NORMAL_TILE_SIZE) / 4;
  localparam int N_Q9   = (9 * NORMAL_TILE_SIZE) / 4;
  localparam int N_STEP = (3 * NORMAL_TILE_SIZE) / 2;
  localparam int Z_TS   = ZOOM_TILE_SIZE;
  localparam int Z_HALF = ZOOM_TILE_SIZE / 2;
  localparam int Z_Q1   = ZOOM_TILE_SIZE / 4;
  localparam int Z_Q3   = (3 * ZOOM_TILE_SIZE) / 4;
  localparam int Z_Q5   = (5 * ZOOM_TILE_SIZE) / 4;
  localparam int Z_Q9   = (9 * ZOOM_TILE_SIZE) / 4;
  localparam int Z_STEP = (3 * ZOOM_TILE_SIZE) / 2;

  typedef logic signed [AW-1:0] val_t;

  // y >= trunc(n/2) and y <= trunc(n/2), with y2 = 2*y
  function automatic logic ge_half(val_t y2, val_t n);
    return y2 >= n - val_t'({1'b0, !n[AW-1]});
  endfunction

  function automatic logic le_half(val_t y2, val_t n);
    return y2 <= n + val_t'({1'b0, n[AW-1]});
  endfunction

  logic signed [phtp_pkg::COORD_W-1:0] click_x_q, click_y_q;
  val_t x_q, y2_q, offmx_q, colbase_q;
  val_t na_q, nb_q, nc_q, nd_q, rowlim_q;
  logic [CW-1:0] col_q, hit_col_q;
  logic [RW-1:0] row_q, hit_row_q;
  logic [TW-1:0] tile_col_q, tile_row_q;

  val_t ts, half, q1, q3, q5, q9, step;
  val_t w_s, h_s, cx, cy;
  val_t a_c, b_c, c_c, d_c;
  logic even_sel;

  always_comb begin
    if (cfg_i.zoom_on) begin
      ts   = val_t'(Z_TS);
      half = val_t'(Z_HALF);
      q1   = val_t'(Z_Q1);
      q3   = val_t'(Z_Q3);
      q5   = val_t'(Z_Q5);
      q9   = val_t'(Z_Q9);
      step = val_t'(Z_STEP);
      w_s  = val_t'({1'b0, cfg_i.zoomed_width});
      h_s  = val_t'({1'b0, cfg_i.zoomed_height});
    end else begin
      ts   = val_t'(N_TS);
      half = val_t'(N_HALF);
      q1   = val_t'(N_Q1);
      q3   = val_t'(N_Q3);
      q5   = val_t'(N_Q5);
      q9   = val_t'(N_Q9);
      step = val_t'(N_STEP);
      w_s  = val_t'({1'b0, cfg_i.normal_width});
      h_s  = val_t'({1'b0, cfg_i.normal_height});
    end
    cx = val_t'(cfg_i.center_x) - (w_s >>> 1);
    cy = val_t'(cfg_i.center_y) - (h_s >>> 1);
  end

  // line offsets of the first hexagon in a row group
  assign even_sel = cmd_i.even_init;
  always_comb begin
    if (even_sel) begin
      a_c = q5;
      b_c = q1;
      c_c = q5;
      d_c = q9;
    end else begin
      a_c = q1;
      b_c = -q1;
      c_c = q3;
      d_c = q5;
    end
  end

  always_comb begin
    stat_o.col_ok     = (col_q <= CW'(MAX_TILES)) && (colbase_q + ts + half <= w_s);
    stat_o.x_in_odd   = (x_q >= colbase_q) && (x_q <= colbase_q + ts);
    stat_o.x_in_even  = (x_q >= colbase_q + half) && (x_q <= colbase_q + ts + half);
    stat_o.row_ok     = (row_q <= RW'(MAX_TILES)) &&
                        ((row_q == RW'(1)) ? (h_s > ts - q3) : (rowlim_q <= h_s));
    stat_o.lower_miss = !(ge_half(y2_q, na_q) && ge_half(y2_q, nb_q));
    stat_o.hit        = !stat_o.lower_miss && le_half(y2_q, nc_q) && le_half(y2_q, nd_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      click_x_q <= click_x_i;
      click_y_q <= click_y_i;
    end
    if (cmd_i.load) begin
      x_q       <= val_t'(click_x_q) - cx;
      y2_q      <= (val_t'(click_y_q) - cy) <<< 1;
      offmx_q   <= cx - val_t'(click_x_q);
      colbase_q <= '0;
      col_q     <= CW'(1);
      hit_col_q <= '0;
      hit_row_q <= '0;
    end
    if (cmd_i.col_next) begin
      col_q     <= col_q + CW'(1);
      colbase_q <= colbase_q + ts;
      offmx_q   <= offmx_q + (half <<< 1);
    end
    if (cmd_i.odd_init || cmd_i.even_init) begin
      na_q     <= (a_c <<< 1) + offmx_q;
      nb_q     <= (b_c <<< 1) - offmx_q;
      nc_q     <= (c_c <<< 1) - offmx_q;
      nd_q     <= (d_c <<< 1) + offmx_q;
      row_q    <= even_sel ? RW'(2) : RW'(1);
      rowlim_q <= even_sel ? ts + q3 : ts;
    end
    if (cmd_i.row_next) begin
      na_q     <= na_q + (step <<< 1);
      nb_q     <= nb_q + (step <<< 1);
      nc_q     <= nc_q + (step <<< 1);
      nd_q     <= nd_q + (step <<< 1);
      row_q    <= row_q + RW'(2);
      rowlim_q <= rowlim_q + (q3 <<< 1);
    end
    if (cmd_i.capture) begin
      hit_col_q <= col_q;
      hit_row_q <= row_q;
    end
    if (cmd_i.out_load) begin
      tile_col_q <= TW'(hit_col_q);
      tile_row_q <= TW'(hit_row_q);
    end
  end

  assign tile_col_o = tile_col_q;
  assign tile_row_o = tile_row_q;

endmodule

// ===== sv/pixel_to_hex_tile_pick_top.sv =====
// scan: the time from accepted click to result valid grows with the number of columns
//   entered and of row candidates tested by the column/row scan in the datapath
// throughput: one click at a time; a new click is taken as soon as the scan has handed
//   its result to the output register, even while that result waits for ready
// reset: asynchronous active-low, clears config registers, state and output valid
module pixel_to_hex_tile_pick_top #(
  parameter int NORMAL_TILE_SIZE = 100,
  parameter int ZOOM_TILE_SIZE   = 200,
  parameter int MAX_TILES        = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  phtp_cfg_if.sink        cfg_i,
  phtp_click_if.sink      click_i,
  phtp_tile_if.source     tile_o
);

  // config register file; the user must write it only while the picker is idle, the block does not enforce it
  phtp_pkg::cfg_t     cfg;

  // command and status between sequencer and datapath
  phtp_pkg::dp_cmd_t  cmd;
  phtp_pkg::dp_stat_t stat;

  logic in_ready;
  logic out_valid;

  phtp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // sequencer: per column one test of the x ranges, then odd rows then
  // even rows, one row candidate per cycle; first hit in scan order wins
  phtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (click_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (tile_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: incremental line bounds in doubled units (one fractional bit),
  // column and row limits checked with running sums instead of divisions
  phtp_dp #(
    .NORMAL_TILE_SIZE (NORMAL_TILE_SIZE),
    .ZOOM_TILE_SIZE   (ZOOM_TILE_SIZE),
    .MAX_TILES        (MAX_TILES)
  ) u_dp (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .click_x_i  (click_i.click_x),
    .click_y_i  (click_i.click_y),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .tile_col_o (tile_o.tile_col),
    .tile_row_o (tile_o.tile_row)
  );

  assign click_i.ready = in_ready;
  assign tile_o.valid  = out_valid;

endmodule

// ===== bench/pixel_to_hex_tile_pick_top_tb.sv =====
`timescale 1ns / 100ps

module pixel_to_hex_tile_pick_top_tb;

  localparam int NORMAL_TS = 100;
  localparam int ZOOM_TS   = 200;
  localparam int MAX_TILES = 63;

  // index past the register map, the block must drop such a write
  localparam logic [phtp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // expected tile for each accepted click, computed from a shadow of the registers
  class tile_scoreboard;
    typedef struct {
      logic signed [phtp_pkg::COORD_W-1:0] x;
      logic signed [phtp_pkg::COORD_W-1:0] y;
      logic [phtp_pkg::TILE_W-1:0]         col;
      logic [phtp_pkg::TILE_W-1:0]         row;
    } tile_expect_t;

    logic signed [phtp_pkg::COORD_W-1:0] center_x;
    logic signed [phtp_pkg::COORD_W-1:0] center_y;
    logic [phtp_pkg::NDIM_W-1:0]         normal_width;
    logic [phtp_pkg::NDIM_W-1:0]         normal_height;
    logic [phtp_pkg::ZDIM_W-1:0]         zoomed_width;
    logic [phtp_pkg::ZDIM_W-1:0]         zoomed_height;
    logic                                zoom_on;
    tile_expect_t                        expected_tiles[$];
    int                                  mismatches;

    function new();
      center_x      = '0;
      center_y      = '0;
      normal_width  = '0;
      normal_height = '0;
      zoomed_width  = '0;
      zoomed_height = '0;
      zoom_on       = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [phtp_pkg::CFG_IDX_W-1:0] idx,
                            logic [phtp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        phtp_pkg::CFG_CENTER_X:      center_x      = data;
        phtp_pkg::CFG_CENTER_Y:      center_y      = data;
        phtp_pkg::CFG_NORMAL_WIDTH:  normal_width  = data[phtp_pkg::NDIM_W-1:0];
        phtp_pkg::CFG_NORMAL_HEIGHT: normal_height = data[phtp_pkg::NDIM_W-1:0];
        phtp_pkg::CFG_ZOOMED_WIDTH:  zoomed_width  = data[phtp_pkg::ZDIM_W-1:0];
        phtp_pkg::CFG_ZOOMED_HEIGHT: zoomed_height = data[phtp_pkg::ZDIM_W-1:0];
        phtp_pkg::CFG_ZOOM_ON:       zoom_on       = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp_count(longint n);
      if (n < 0) return 0;
      if (n > MAX_TILES) return MAX_TILES;
      return n;
    endfunction

    // bounds kept doubled, then truncated toward zero
    function bit in_hex(longint x, longint y, longint a, longint b, longint c, longint d);
      return y >= (-x + 2 * a) / 2 && y >= (x + 2 * b) / 2 &&
             y <= (x + 2 * c) / 2 && y <= (-x + 2 * d) / 2;
    endfunction

    function void note_click(logic signed [phtp_pkg::COORD_W-1:0] px,
                             logic signed [phtp_pkg::COORD_W-1:0] py);
      tile_expect_t e;
      longint ts, w, h, x, y, ncol, nrow;
      longint half, q1, q3, q5, q9, step, off, v, col, row, hc, hr;
      bit found;
      ts   = zoom_on ? ZOOM_TS : NORMAL_TS;
      w    = zoom_on ? longint'(zoomed_width) : longint'(normal_width);
      h    = zoom_on ? longint'(zoomed_height) : longint'(normal_height);
      x    = longint'(px) - (longint'(center_x) - w / 2);
      y    = longint'(py) - (longint'(center_y) - h / 2);
      ncol = clamp_count((w - ts / 2) / ts);
      nrow = clamp_count((h - ts) / ((3 * ts) / 4) + 1);
      half = ts / 2;
      q1   = ts / 4;
      q3   = (3 * ts) / 4;
      q5   = (5 * ts) / 4;
      q9   = (9 * ts) / 4;
      step = (3 * ts) / 2;
      hc   = 0;
      hr   = 0;
      found = 1'b0;
      for (col = 1; !found && col <= ncol; col++) begin
        off = half * (col - 1);
        // odd rows sit unshifted
        if (x >= ts * (col - 1) && x <= ts * col) begin
          for (row = 1; !found && row <= nrow; row += 2) begin
            v = step * ((row - 1) / 2);
            if (in_hex(x, y, q1 + off + v, -q1 - off + v, q3 - off + v, q5 + off + v)) begin
              found = 1'b1;
              hc = col;
              hr = row;
            end
          end
        end
        // even rows shifted by half a tile
        if (!found && x >= ts * (col - 1) + half && x <= ts * col + half) begin
          for (row = 2; !found && row <= nrow; row += 2) begin
            v = step * ((row - 2) / 2);
            if (in_hex(x, y, q5 + off + v, q1 - off + v, q5 - off + v, q9 + off + v)) begin
              found = 1'b1;
              hc = col;
              hr = row;
            end
          end
        end
      end
      e.x   = px;
      e.y   = py;
      e.col = hc[phtp_pkg::TILE_W-1:0];
      e.row = hr[phtp_pkg::TILE_W-1:0];
      expected_tiles.push_back(e);
    endfunction

    function void check_tile(logic [phtp_pkg::TILE_W-1:0] col,
                             logic [phtp_pkg::TILE_W-1:0] row);
      tile_expect_t e;
      if (expected_tiles.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected tile word: col %0d row %0d", col, row);
        mismatches++;
        return;
      end
      e = expected_tiles.pop_front();
      if (col !== e.col || row !== e.row) begin
        if (mismatches < 10)
          $display("tile mismatch for click (%0d,%0d): expected col %0d row %0d, got col %0d row %0d",
                   e.x, e.y, e.col, e.row, col, row);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  phtp_cfg_if   cfg_bus ();
  phtp_click_if click_bus ();
  phtp_tile_if  tile_bus ();

  pixel_to_hex_tile_pick_top #(
    .NORMAL_TILE_SIZE (NORMAL_TS),
    .ZOOM_TILE_SIZE   (ZOOM_TS),
    .MAX_TILES        (MAX_TILES)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .click_i (click_bus),
    .tile_o  (tile_bus)
  );

  tile_scoreboard sb;

  // current setting as written, used only to aim clicks at the image
  longint cur_cx, cur_cy, cur_nw, cur_nh, cur_zw, cur_zh;
  logic   cur_zoom;
  // clicks still to go back to back with no gap
  int     click_burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("pixel_to_hex_tile_pick_top_tb: FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [phtp_pkg::COORD_W-1:0] to_coord(longint v);
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[phtp_pkg::COORD_W-1:0];
  endfunction

  // result side: random stalls, with long stretches of steady ready
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    tile_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && run_left == 0) begin
        stall_left = gap_len();
        run_left   = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        tile_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        tile_bus.ready <= 1'b1;
        run_left--;
      end
    end
  end

  // every accepted tile word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && tile_bus.valid && tile_bus.ready)
      sb.check_tile(tile_bus.tile_col, tile_bus.tile_row);
  end

  // valid stays up across back-to-back words, lowered only when a gap follows
  task automatic write_reg(logic [phtp_pkg::CFG_IDX_W-1:0] idx,
                           logic [phtp_pkg::CFG_DATA_W-1:0] data);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic send_click(logic signed [phtp_pkg::COORD_W-1:0] x,
                            logic signed [phtp_pkg::COORD_W-1:0] y);
    int gap;
    if (click_burst_left > 0) begin
      gap = 0;
      click_burst_left--;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 39) == 0) click_burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      click_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    click_bus.valid   <= 1'b1;
    click_bus.click_x <= x;
    click_bus.click_y <= y;
    do @(posedge clk_i); while (!click_bus.ready);
    sb.note_click(x, y);
  endtask

  // stop sending and wait until every tile word is back
  task automatic drain_clicks();
    click_bus.valid <= 1'b0;
    while (sb.expected_tiles.size() != 0) @(posedge clk_i);
  endtask

  // block is idle here; upper bits of the size words carry junk that must be dropped
  task automatic load_config(logic signed [phtp_pkg::COORD_W-1:0] cx,
                             logic signed [phtp_pkg::COORD_W-1:0] cy,
                             logic [phtp_pkg::NDIM_W-1:0] nw, logic [phtp_pkg::NDIM_W-1:0] nh,
                             logic [phtp_pkg::ZDIM_W-1:0] zw, logic [phtp_pkg::ZDIM_W-1:0] zh,
                             logic zm);
    logic [phtp_pkg::CFG_DATA_W-1:0] junk;
    junk = 16'($urandom);
    write_reg(phtp_pkg::CFG_CENTER_X, cx);
    write_reg(phtp_pkg::CFG_CENTER_Y, cy);
    write_reg(phtp_pkg::CFG_NORMAL_WIDTH, (junk & 16'hF000) | nw);
    write_reg(phtp_pkg::CFG_NORMAL_HEIGHT, ({junk[11:0], junk[15:12]} & 16'hF000) | nh);
    write_reg(phtp_pkg::CFG_ZOOMED_WIDTH, ({junk[7:0], junk[15:8]} & 16'hE000) | zw);
    write_reg(phtp_pkg::CFG_ZOOMED_HEIGHT, ({junk[3:0], junk[15:4]} & 16'hE000) | zh);
    write_reg(phtp_pkg::CFG_ZOOM_ON, (~junk & 16'hFFFE) | zm);
    // a write past the map must leave everything alone
    if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_UNUSED, 16'($urandom));
    cfg_bus.valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_nw = nw;
    cur_nh = nh;
    cur_zw = zw;
    cur_zh = zh;
    cur_zoom = zm;
  endtask

  // most clicks land on or near the image, the rest anywhere on screen
  task automatic random_click();
    longint w, h, ox, oy;
    w  = cur_zoom ? cur_zw : cur_nw;
    h  = cur_zoom ? cur_zh : cur_nh;
    ox = cur_cx - w / 2;
    oy = cur_cy - h / 2;
    if ($urandom_range(0, 9) < 7)
      send_click(to_coord(ox - 20 + $urandom_range(0, int'(w + 40))),
                 to_coord(oy - 20 + $urandom_range(0, int'(h + 40))));
    else
      send_click(16'($urandom), 16'($urandom));
  endtask

  function automatic int pick_dim(int maxv);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(100, maxv);
    if (r < 8) return $urandom_range(0, 250);
    return maxv;
  endfunction

  initial begin
    logic signed [phtp_pkg::COORD_W-1:0] cx, cy;
    sb = new();
    click_burst_left = 0;
    cur_cx = 0;
    cur_cy = 0;
    cur_nw = 0;
    cur_nh = 0;
    cur_zw = 0;
    cur_zh = 0;
    cur_zoom = 1'b0;
    rst_ni = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    click_bus.valid   = 1'b0;
    click_bus.click_x = '0;
    click_bus.click_y = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: zero-size image, nothing can be hit
    send_click(0, 0);
    send_click(-32768, -32768);
    send_click(32767, 32767);
    drain_clicks();

    // normal grid, corner at (0,50) on screen: tile centers, edges, odd-pixel bounds
    load_config(500, 400, 1000, 700, 2000, 1500, 1'b0);
    send_click(50, 100);
    send_click(100, 175);
    send_click(150, 100);
    send_click(850, 100);
    send_click(0, 50);
    send_click(-1, 49);
    send_click(1000, 750);
    send_click(551, 261);
    drain_clicks();

    // zoomed grid, tile size doubles
    load_config(0, 0, 1000, 700, 2000, 1500, 1'b1);
    send_click(-900, -650);
    send_click(-800, -500);
    send_click(999, 749);
    drain_clicks();

    // largest images at the far corners of the screen range
    load_config(-32768, 32767, 4095, 4095, 8191, 8191, 1'b0);
    send_click(-32768, 32767);
    send_click(-32000, 31000);
    drain_clicks();
    load_config(-32768, 32767, 4095, 4095, 8191, 8191, 1'b1);
    send_click(-32768, 32767);
    send_click(32767, -32768);
    drain_clicks();

    // images too small for a single column, and no rows at all
    load_config(0, 0, 49, 30, 99, 0, 1'b0);
    send_click(0, 0);
    send_click(-20, -10);
    drain_clicks();
    load_config(0, 0, 49, 30, 99, 0, 1'b1);
    send_click(0, 0);
    drain_clicks();

    // random settings, each followed by a batch of clicks
    for (int phase = 0; phase < 10; phase++) begin
      cx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      cy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      load_config(cx, cy, 12'(pick_dim(4095)), 12'(pick_dim(4095)),
                  13'(pick_dim(8191)), 13'(pick_dim(8191)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 80; i++) begin
        // hold off mid-batch until the block has caught up
        if (i == 37) drain_clicks();
        random_click();
      end
      drain_clicks();
    end

    repeat (250) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_tiles.size() == 0) begin
      $display("pixel_to_hex_tile_pick_top_tb: PASS");
    end else begin
      $display("pixel_to_hex_tile_pick_top_tb: FAIL");
    end
    $finish;
  end

endmodule
